// ===== rtl/sorted_min_priority_queue_core_macros.svh =====
// Assertion macros for the priority queue checker
`ifndef SORTED_MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_MIN_PRIORITY_QUEUE_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define SMPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("smpq assertion failed");

// Check that a condition leads to another one on the next edge
`define SMPQ_ASSERT_NEXT(lbl, cond, expect_nxt) \
  `SMPQ_ASSERT(lbl, (cond) |=> (expect_nxt))

`endif

// ===== rtl/smpq_pkg.sv =====
// Package for the sorted minimum priority queue: sizes, codes and item types
`default_nettype none

package smpq_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int HELD_W = 5;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } smpq_kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } smpq_status_t;

  typedef struct packed {
    smpq_kind_t         kind;
    logic [VAL_W-1:0]   value;
  } smpq_in_t;

  typedef struct packed {
    smpq_status_t       status;
    logic [VAL_W-1:0]   popped_value;
    logic [VAL_W-1:0]   smallest_now;
    logic [HELD_W-1:0]  held_count;
    logic               is_empty;
  } smpq_out_t;

  // Operation broadcast to every cell of the row
  typedef struct packed {
    logic               push_en;
    logic               pop_en;
    logic [VAL_W-1:0]   value;
  } smpq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/smpq_cell.sv =====
// One cell of the sorted row: holds one value and trades it with its neighbors
`default_nettype none

module smpq_cell
  import smpq_pkg::*;
(
  input  wire logic             clk,
  input  wire smpq_cmd_t        cmd,
  input  wire logic             occupied,
  input  wire logic             left_le,
  input  wire logic [VAL_W-1:0] left_val,
  input  wire logic [VAL_W-1:0] right_val,
  output logic                  le,
  output logic [VAL_W-1:0]      val_q,
  output logic [VAL_W-1:0]      val_nxt
);

  logic [VAL_W-1:0] val_r;

  // Flag a held value that the new value must go after
  assign le = occupied && (val_r <= cmd.value);

  // Keep, insert or shift right on push; shift left on pop
  always_comb begin
    val_nxt = val_r;
    if (cmd.push_en) begin
      if (le) begin
        val_nxt = val_r;
      end else if (left_le) begin
        val_nxt = cmd.value;
      end else begin
        val_nxt = left_val;
      end
    end else if (cmd.pop_en) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q = val_r;

endmodule

`default_nettype wire

// ===== rtl/sorted_min_priority_queue_core.sv =====
// The result of each accepted item is registered into the output register.
// Throughput: one push or pop per cycle while not stalled; every cell compares against
// the new value at once. The row shifts one place per item, so no item waits on another.
// Reset clears the fill count and the output valid; cell contents stay undefined.
// Stall on the input follows only a full output register that is itself stalled.
`default_nettype none

module sorted_min_priority_queue_core
  import smpq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire smpq_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output smpq_out_t      out_data
);

  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  smpq_out_t            out_data_r;
  smpq_out_t            result;
  smpq_cmd_t            cmd;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [DEPTH:0]       le_chain;
  logic [VAL_W-1:0]     cell_q   [DEPTH];
  logic [VAL_W-1:0]     cell_nxt [DEPTH];
  logic [CNT_W+HELD_W-1:0] count_ext;

  // Take an item unless a finished result is held and stalled
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  assign cmd.push_en = accept && (in_data.kind == KIND_PUSH) && !full;
  assign cmd.pop_en  = accept && (in_data.kind == KIND_POP) && !empty;
  assign cmd.value   = in_data.value;

  // Build the row of cells
  assign le_chain[0] = 1'b1;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_v;
    logic [VAL_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = cell_q[i+1];
    end
    smpq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occupied  (CNT_W'(i) < count_r),
      .left_le   (le_chain[i]),
      .left_val  (left_v),
      .right_val (right_v),
      .le        (le_chain[i+1]),
      .val_q     (cell_q[i]),
      .val_nxt   (cell_nxt[i])
    );
  end

  // Advance the fill count
  always_comb begin
    count_nxt = count_r;
    if (cmd.push_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign count_ext = {{HELD_W{1'b0}}, count_nxt};

  // Form the result from the item and the state before and after it
  always_comb begin
    result.status = ST_DONE;
    if (in_data.kind == KIND_PUSH && full) begin
      result.status = ST_FULL;
    end else if (in_data.kind == KIND_POP && empty) begin
      result.status = ST_EMPTY;
    end
    result.popped_value = cmd.pop_en ? cell_q[0] : '0;
    result.smallest_now = (count_nxt != '0) ? cell_nxt[0] : '0;
    result.held_count   = count_ext[HELD_W-1:0];
    result.is_empty     = (count_nxt == '0);
  end

  // Load the output register on accept, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/smpq_checker.sv =====
// Port-level checker for the priority queue, bound to the top level
`default_nettype none

`include "sorted_min_priority_queue_core_macros.svh"

module smpq_checker
  import smpq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire smpq_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire smpq_out_t out_data
);

  logic in_take;

  assign in_take = in_valid && !in_stall;

  // A stalled result stays offered
  `SMPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // Every accepted item shows a result on the next edge
  `SMPQ_ASSERT_NEXT(a_item_result, in_take, out_valid)

  // A pop on an empty queue leaves it empty and returns nothing
  `SMPQ_ASSERT(a_pop_empty, (out_valid && out_data.status == ST_EMPTY) |-> (out_data.is_empty && out_data.held_count == '0 && out_data.popped_value == '0))

  // An empty queue reports no count and no smallest value
  `SMPQ_ASSERT(a_empty_fields, (out_valid && out_data.is_empty) |-> (out_data.held_count == '0 && out_data.smallest_now == '0))

  // A rejected push comes from a non-empty queue and pops nothing
  `SMPQ_ASSERT(a_full_reject, (out_valid && out_data.status == ST_FULL) |-> (!out_data.is_empty && out_data.popped_value == '0))

endmodule

bind sorted_min_priority_queue_core smpq_checker u_smpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
